/* src/kmc_pkg.sv */
// kmc_pkg: shared types and constants for the color k-means core.
// No dependencies.
`timescale 1ns / 1ps
package kmc_pkg;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned FixW   = 16;
  localparam int unsigned PointW = 3 * ChanW;
  localparam int unsigned CentW  = 3 * FixW;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned DistW  = 34;

  localparam logic [0:0] RegClusterCount = 1'b0;
  localparam logic [0:0] RegEpochCount   = 1'b1;

  typedef struct packed {
    logic       start;
    logic [7:0] numer_hi;
    logic [7:0] numer_lo;
  } kmc_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [FixW-1:0] quot;
  } kmc_div_rsp_t;
endpackage

/* src/kmc_if.sv */
// kmc_if: valid/ready channel carrying one payload word.
// Depends on nothing; payload width set by parameter.
`timescale 1ns / 1ps
interface kmc_if #(
  parameter int unsigned W = 8
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/kmc_ram.sv */
// kmc_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kmc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* src/kmc_div.sv */
// kmc_div: restoring divider, one quotient bit per cycle.
// Depends on kmc_pkg. Computes floor(sum*256/size), truncated to 16 bits.
`timescale 1ns / 1ps
module kmc_div
  import kmc_pkg::*;
#(
  parameter int unsigned SumW  = 20,
  parameter int unsigned SizeW = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  sum_i,
  input  logic [SizeW-1:0] size_i,
  output kmc_div_rsp_t     rsp_o
);
  localparam int unsigned NumW = SumW + 8;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  num_q, num_d;
  logic [SizeW:0]   rem_q, rem_d;
  logic [SizeW-1:0] den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, done_q;
  logic [SizeW:0]   trial;
  logic [SizeW+1:0] diff;

  always_comb begin
    trial = {rem_q[SizeW-1:0], num_q[NumW-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    num_d = {num_q[NumW-2:0], ~diff[SizeW+1]};
    rem_d = diff[SizeW+1] ? trial : diff[SizeW:0];
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        num_q  <= {sum_i, 8'h00};
        rem_q  <= '0;
        den_q  <= size_i;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_d;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q[FixW-1:0];
endmodule

/* src/kmeans_color_clustering_core.sv */
// Color k-means core: point load, Lloyd epochs, centroid readout.
// Depends on kmc_pkg, kmc_if, kmc_ram, kmc_div.
//
// channel   dir  handshake     payload
// pt_if     in   valid/ready   red, green, blue, last
// cen_if    out  valid/ready   red, green, blue (8.8), index, last, too_few
// apb       in   psel/penable  cluster_count (0x0), epoch_count (0x4)
//
// Load: one point per cycle. Run: seed centroids from the first k points;
// per epoch assign each point to its nearest centroid, then divide channel
// sums per cluster (empty: zeroed); readout k words, held while cen_if stalls.
// One distance term per cycle through one shared multiplier.
// Reset clears control; point memory is not cleared (read only below count).
// Input is not ready during a run or while results drain.
`timescale 1ns / 1ps
module kmeans_color_clustering_core
  import kmc_pkg::*;
#(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kmc_if.sink         pt_if,
  kmc_if.source       cen_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned KW    = $clog2(MAX_CLUSTERS);
  localparam int unsigned KCW   = KW + 1;
  localparam int unsigned SumW  = ChanW + NW;

  typedef enum logic [3:0] {
    SLoad, SInit, SInitW, SClr, SRd, SRdW, SDist, SAcc, SUpd, SDivW, SOut
  } state_e;

  state_e           st_q;
  logic [4:0]       kcfg_q;
  logic [7:0]       ecfg_q;
  logic [NW-1:0]    n_q;
  logic [AW-1:0]    i_q;
  logic [KCW-1:0]   j_q, best_q;
  logic [1:0]       ch_q;
  logic [7:0]       ep_q;
  logic             few_q;
  logic [DistW-1:0] acc_q, best_d_q;
  logic [PointW-1:0] pt_q;
  logic [CentW-1:0] cent_q [MAX_CLUSTERS];
  logic [SumW-1:0]  sum_q  [MAX_CLUSTERS][3];
  logic [NW-1:0]    size_q [MAX_CLUSTERS];
  logic [KCW-1:0]   k;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PointW-1:0] ram_rd;

  always_comb begin
    if (kcfg_q == 5'd0) k = KCW'(1);
    else if (32'(kcfg_q) > MAX_CLUSTERS) k = KCW'(MAX_CLUSTERS);
    else k = KCW'(kcfg_q);
  end

  assign pt_if.ready = (st_q == SLoad);
  assign ram_we      = pt_if.valid && pt_if.ready && (n_q < NW'(MAX_POINTS));
  assign ram_addr    = ram_we ? n_q[AW-1:0] : i_q;

  kmc_ram #(.Width(PointW), .Depth(MAX_POINTS)) u_pts (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(pt_if.data[PointW:1]), .rdata_o(ram_rd)
  );

  // distance term: one channel of one centroid per cycle
  logic [FixW-1:0]  pv, cv, dv;
  logic [2*FixW-1:0] sq;
  always_comb begin
    pv = {pt_q[(2-ch_q)*ChanW +: ChanW], 8'h00};
    cv = cent_q[j_q[KW-1:0]][(2-ch_q)*FixW +: FixW];
    dv = (pv > cv) ? pv - cv : cv - pv;
    sq = dv * dv;
  end

  logic             div_start;
  kmc_div_rsp_t     div_rsp;
  kmc_div #(.SumW(SumW), .SizeW(NW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .sum_i(sum_q[j_q[KW-1:0]][ch_q]), .size_i(size_q[j_q[KW-1:0]]), .rsp_o(div_rsp)
  );
  assign div_start = (st_q == SUpd) && (size_q[j_q[KW-1:0]] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SLoad;
      kcfg_q <= 5'd4;
      ecfg_q <= 8'd10;
      n_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      ch_q   <= '0;
      ep_q   <= '0;
      few_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          RegClusterCount: kcfg_q <= pwdata[4:0];
          RegEpochCount:   ecfg_q <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (st_q)
        SLoad: if (pt_if.valid) begin
          if (ram_we) n_q <= n_q + NW'(1);
          if (pt_if.data[0]) begin
            few_q <= (ram_we ? n_q + NW'(1) : n_q) < NW'(k);
            ep_q  <= '0;
            i_q   <= '0;
            j_q   <= '0;
            st_q  <= ((ram_we ? n_q + NW'(1) : n_q) < NW'(k)) ? SOut : SInit;
          end
        end
        SInit: st_q <= SInitW;
        SInitW: begin
          cent_q[j_q[KW-1:0]] <= {ram_rd[23:16], 8'h00, ram_rd[15:8], 8'h00,
                                  ram_rd[7:0], 8'h00};
          if (j_q == k - KCW'(1)) begin
            j_q <= '0;
            st_q <= SClr;
          end else begin
            j_q <= j_q + KCW'(1);
            i_q <= i_q + AW'(1);
            st_q <= SInit;
          end
        end
        SClr: begin
          if (ep_q == ecfg_q) begin
            j_q <= '0;
            st_q <= SOut;
          end else begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
              size_q[c] <= '0;
              for (int h = 0; h < 3; h++) sum_q[c][h] <= '0;
            end
            i_q <= '0;
            st_q <= SRd;
          end
        end
        SRd: st_q <= SRdW;
        SRdW: begin
          pt_q <= ram_rd;
          j_q <= '0;
          ch_q <= '0;
          acc_q <= '0;
          st_q <= SDist;
        end
        SDist: begin
          if (ch_q == 2'd2) begin
            ch_q <= '0;
            if (j_q == '0 || (acc_q + DistW'(sq)) < best_d_q) begin
              best_d_q <= acc_q + DistW'(sq);
              best_q <= j_q;
            end
            acc_q <= '0;
            if (j_q == k - KCW'(1)) st_q <= SAcc;
            else j_q <= j_q + KCW'(1);
          end else begin
            acc_q <= acc_q + DistW'(sq);
            ch_q <= ch_q + 2'd1;
          end
        end
        SAcc: begin
          for (int h = 0; h < 3; h++) begin
            sum_q[best_q[KW-1:0]][h] <= sum_q[best_q[KW-1:0]][h] +
                                        SumW'(pt_q[(2-h)*ChanW +: ChanW]);
          end
          size_q[best_q[KW-1:0]] <= size_q[best_q[KW-1:0]] + NW'(1);
          if (NW'(i_q) + NW'(1) == n_q) begin
            j_q <= '0;
            ch_q <= '0;
            st_q <= SUpd;
          end else begin
            i_q <= i_q + AW'(1);
            st_q <= SRd;
          end
        end
        SUpd: begin
          if (size_q[j_q[KW-1:0]] == '0) begin
            cent_q[j_q[KW-1:0]] <= '0;
            j_q <= j_q + KCW'(1);
            if (j_q == k - KCW'(1)) begin
              ep_q <= ep_q + 8'd1;
              st_q <= SClr;
            end
          end else begin
            st_q <= SDivW;
          end
        end
        SDivW: if (div_rsp.done) begin
          cent_q[j_q[KW-1:0]][(2-ch_q)*FixW +: FixW] <= div_rsp.quot;
          st_q <= SUpd;
          if (ch_q == 2'd2) begin
            ch_q <= '0;
            j_q <= j_q + KCW'(1);
            if (j_q == k - KCW'(1)) begin
              ep_q <= ep_q + 8'd1;
              st_q <= SClr;
            end
          end else begin
            ch_q <= ch_q + 2'd1;
          end
        end
        SOut: if (cen_if.ready) begin
          if (j_q == k - KCW'(1)) begin
            n_q <= '0;
            j_q <= '0;
            st_q <= SLoad;
          end else begin
            j_q <= j_q + KCW'(1);
          end
        end
        default: st_q <= SLoad;
      endcase
    end
  end

  logic [CentW-1:0] cur;
  assign cur = few_q ? '0 : cent_q[j_q[KW-1:0]];
  assign cen_if.valid = (st_q == SOut);
  assign cen_if.data  = {cur, IdxW'(j_q), (j_q == k - KCW'(1)), few_q};

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegEpochCount) ? {24'h0, ecfg_q} : {27'h0, kcfg_q};

  a_out_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cen_if.valid |-> j_q < k) else $error("index beyond k");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_if.ready |-> !cen_if.valid) else $error("load overlaps readout");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp.busy) else $error("divider restarted");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_POINTS)) else $error("point count overflow");
endmodule

/* test/tb_kmeans_color_clustering_core.sv */
// Testbench for kmeans_color_clustering_core: loads random and directed RGB point
// sets, sweeps the cluster and epoch registers, and checks every centroid word.
// Depends on kmc_pkg, kmc_if and the core RTL.
`timescale 1ns / 1ps
module tb_kmeans_color_clustering_core;
  import kmc_pkg::*;

  localparam int unsigned MaxPts  = 4096;
  localparam int unsigned MaxClus = 16;
  localparam longint      CycleLimit = 3000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } point_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [3:0]  index;
    logic        last;
    logic        too_few;
  } centroid_t;

  class centroid_scoreboard;
    logic [7:0]  pts [MaxPts][3];
    int unsigned n_pts;
    logic [15:0] cent [MaxClus][3];
    longint unsigned sums [MaxClus][3];
    int unsigned sizes [MaxClus];
    logic [4:0]  k_reg;
    logic [7:0]  epochs_reg;
    centroid_t   pending [$];
    int unsigned errors;

    function new();
      n_pts = 0;
      k_reg = 5'd4;
      epochs_reg = 8'd10;
      errors = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] val);
      if (idx == RegClusterCount) k_reg = val[4:0];
      else epochs_reg = val[7:0];
    endfunction

    function longint unsigned sq_dist(int unsigned i, int unsigned j);
      longint unsigned tot, d;
      logic [31:0] pv;
      tot = 0;
      for (int ch = 0; ch < 3; ch++) begin
        pv = {16'd0, pts[i][ch], 8'd0};
        d = 64'((pv > cent[j][ch]) ? pv - cent[j][ch] : cent[j][ch] - pv);
        tot += d * d;
      end
      return tot;
    endfunction

    function void note_point(point_t p);
      int unsigned k, best;
      longint unsigned bd, d;
      bit few;
      centroid_t c;
      if (n_pts < MaxPts) begin
        pts[n_pts][0] = p.red;
        pts[n_pts][1] = p.green;
        pts[n_pts][2] = p.blue;
        n_pts++;
      end
      if (!p.last) return;
      k = k_reg;
      if (k < 1) k = 1;
      if (k > MaxClus) k = MaxClus;
      few = n_pts < k;
      if (!few) begin
        for (int j = 0; j < k; j++)
          for (int ch = 0; ch < 3; ch++) cent[j][ch] = {pts[j][ch], 8'd0};
        for (int e = 0; e < epochs_reg; e++) begin
          for (int j = 0; j < MaxClus; j++) begin
            sizes[j] = 0;
            for (int ch = 0; ch < 3; ch++) sums[j][ch] = 0;
          end
          for (int i = 0; i < n_pts; i++) begin
            best = 0;
            bd = sq_dist(i, 0);
            for (int j = 1; j < k; j++) begin
              d = sq_dist(i, j);
              if (d < bd) begin
                bd = d;
                best = j;
              end
            end
            for (int ch = 0; ch < 3; ch++) sums[best][ch] += pts[i][ch];
            sizes[best]++;
          end
          for (int j = 0; j < k; j++)
            for (int ch = 0; ch < 3; ch++)
              cent[j][ch] = (sizes[j] == 0) ? 16'd0 :
                            16'(((sums[j][ch] << 8) / sizes[j]) & 64'hffff);
        end
      end
      for (int j = 0; j < k; j++) begin
        c.red     = few ? 16'd0 : cent[j][0];
        c.green   = few ? 16'd0 : cent[j][1];
        c.blue    = few ? 16'd0 : cent[j][2];
        c.index   = 4'(j);
        c.last    = (j + 1 == k);
        c.too_few = few;
        pending = {pending, c};
      end
      n_pts = 0;
    endfunction

    function void check_result(centroid_t got);
      centroid_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected centroid word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"centroid mismatch: exp r=%h g=%h b=%h i=%0d l=%b f=%b,",
                    " got r=%h g=%h b=%h i=%0d l=%b f=%b"},
                   want.red, want.green, want.blue, want.index, want.last, want.too_few,
                   got.red, got.green, got.blue, got.index, got.last, got.too_few);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kmc_if #(.W($bits(point_t)))    pt_ch ();
  kmc_if #(.W($bits(centroid_t))) cen_ch ();

  kmeans_color_clustering_core dut (
    .clk_i, .rst_ni, .pt_if(pt_ch.sink), .cen_if(cen_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  centroid_scoreboard sb = new();
  longint cycles = 0;
  int unsigned stall_left = 0;
  bit no_stall_mode = 0;

  always #4 clk_i = ~clk_i;

  initial begin
    pt_ch.valid = 1'b0;
    pt_ch.data  = '0;
    cen_ch.ready = 1'b0;
  end

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cen_ch.valid && cen_ch.ready) sb.check_result(centroid_t'(cen_ch.data));
    if ($urandom_range(199) == 0) no_stall_mode <= ~no_stall_mode;
    if (no_stall_mode) begin
      cen_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      cen_ch.ready <= 1'b0;
    end else begin
      stall_left <= rand_gap();
      cen_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(int unsigned idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_point(point_t p, bit gaps);
    int unsigned g;
    pt_ch.valid <= 1'b1;
    pt_ch.data <= p;
    do @(posedge clk_i); while (!pt_ch.ready);
    sb.note_point(p);
    g = gaps ? rand_gap() : 0;
    if (g > 0 || p.last) begin
      pt_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_set(int unsigned n, int unsigned k, int unsigned e, bit clumped);
    point_t p;
    logic [7:0] base [8][3];
    int unsigned b;
    wait_drained();
    write_reg(RegClusterCount, k);
    write_reg(RegEpochCount, e);
    for (int i = 0; i < 8; i++)
      for (int ch = 0; ch < 3; ch++) base[i][ch] = 8'($urandom_range(255));
    for (int i = 0; i < n; i++) begin
      b = $urandom_range(7);
      if (clumped) begin
        p.red   = base[b][0] ^ 8'($urandom_range(15));
        p.green = base[b][1] ^ 8'($urandom_range(15));
        p.blue  = base[b][2] ^ 8'($urandom_range(15));
      end else begin
        p.red   = 8'($urandom_range(255));
        p.green = 8'($urandom_range(255));
        p.blue  = 8'($urandom_range(255));
      end
      p.last = (i == n - 1);
      send_point(p, 1'b1);
    end
  endtask

  int unsigned sent;
  int unsigned n, k, e;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config k=4, e=10: extremes and exact ties
    send_point('{8'h00, 8'h00, 8'h00, 1'b0}, 1'b0);
    send_point('{8'hff, 8'hff, 8'hff, 1'b0}, 1'b0);
    send_point('{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1);
    send_point('{8'haa, 8'h55, 8'haa, 1'b0}, 1'b0);
    send_point('{8'h55, 8'haa, 8'h55, 1'b0}, 1'b0);
    send_point('{8'h80, 8'h80, 8'h80, 1'b0}, 1'b0);
    send_point('{8'h7f, 8'h7f, 8'h7f, 1'b1}, 1'b1);
    // too few points
    wait_drained();
    send_point('{8'h12, 8'h34, 8'h56, 1'b1}, 1'b0);
    // k=0 acts as 1, single point
    send_set(1, 0, 3, 0);
    // k above range, 31 acts as 16
    send_set(20, 31, 2, 1);
    send_set(16, 16, 1, 0);
    send_set(15, 16, 1, 0);
    send_set(6, 17, 1, 0);
    // zero and maximum epochs
    send_set(8, 5, 0, 0);
    send_set(4, 1, 255, 0);
    send_set(4, 2, 255, 1);
    send_set(10, 3, 1, 0);

    sent = 0;
    while (sent < 320) begin
      k = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
      if ($urandom_range(9) == 0) n = $urandom_range(k, 1);
      else n = $urandom_range(k + 25, k);
      e = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
      if (k > 8 && e > 4) e = 4;
      send_set(n, k, e, $urandom_range(3) != 0);
      sent += n;
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
